[rtl/cu_pkg.sv]
// ----------------------------------------------------------------------------
// cu_pkg: shared types, constants and the binomial table
// Holds the configuration register indexes and C(u,d) lookup for the unranker.
// ----------------------------------------------------------------------------
package cu_pkg;

	localparam int unsigned MaxN      = 32;
	localparam int unsigned CfgW      = 6;
	localparam int unsigned CodeW     = 31;
	localparam int unsigned BinW      = 32;

	localparam logic [0:0] REG_ITEM_COUNT   = 1'b0;
	localparam logic [0:0] REG_CHOSEN_COUNT = 1'b1;

	// C(u,d) for u < 32; zero when d > u. The table rows are built from
	// Pascal's rule on constants only, so the lookup reduces to a mux on u,d.
	// Every entry with u <= 31 fits in 32 bits.
	function automatic logic [BinW-1:0] binom_tab(input logic [4:0] u, input logic [5:0] d);
		logic [BinW-1:0] row [33];
		logic [BinW-1:0] val;
		val = '0;
		for (int k = 0; k < 33; k++) begin
			row[k] = '0;
		end
		row[0] = BinW'(1);
		for (int uu = 0; uu < 32; uu++) begin
			if (uu > 0) begin
				for (int k = 32; k > 0; k--) begin
					row[k] = row[k] + row[k-1];
				end
			end
			for (int k = 0; k < 33; k++) begin
				if (u == 5'(uu) && d == 6'(k)) begin
					val = row[k];
				end
			end
		end
		return val;
	endfunction

	typedef struct packed {
		logic [5:0] n;
		logic [5:0] r;
	} cu_cfg_t;

endpackage

[rtl/combination_unrank.sv]
// ----------------------------------------------------------------------------
// combination_unrank: combinatorial number system unranker
// Decodes a rank code into an n-bit mask with r bits set.
// ----------------------------------------------------------------------------
// One request enters per cycle while in_stall is low, and its mask leaves the
// last stage of the pipe (one pipeline stage per mask position, each a table
// lookup of C(u,d) and a 31-bit compare-subtract). The settings n and r are
// sampled with the request and travel alongside it. A stall on the output freezes
// the whole pipeline while the last stage holds a result; bubbles are not squeezed out.
// Codes at or above C(n,r) are not flagged and give fewer than r set bits.
module combination_unrank #(
	parameter int unsigned MAX_N = cu_pkg::MaxN
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [0:0]               cfg_index,
	input  logic [cu_pkg::CfgW-1:0]  cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [cu_pkg::CodeW-1:0] rank_code,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [31:0]              selection_mask
);
	import cu_pkg::*;

	cu_cfg_t cfg_q;
	cu_cfg_t cfg_eff;

	logic             v   [MAX_N+1];
	cu_cfg_t          cf  [MAX_N+1];
	logic [CodeW-1:0] cd  [MAX_N+1];
	logic [5:0]       cc  [MAX_N+1];
	logic [MAX_N-1:0] mk  [MAX_N+1];
	logic             advance;

	// register writes; index decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.n <= 6'd32;
			cfg_q.r <= 6'd16;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ITEM_COUNT:   cfg_q.n <= cfg_data;
				REG_CHOSEN_COUNT: cfg_q.r <= cfg_data;
				default: ;
			endcase
		end
	end

	// saturate n at MAX_N before it enters the pipe
	always_comb begin
		cfg_eff   = cfg_q;
		if (cfg_q.n > 6'(MAX_N)) begin
			cfg_eff.n = 6'(MAX_N);
		end
	end

	// hold everything while the finished result waits
	assign advance  = !(v[MAX_N] && out_stall);
	assign in_stall = !advance;

	assign v[0]  = in_valid;
	assign cf[0] = cfg_eff;
	assign cd[0] = rank_code;
	assign cc[0] = 6'd0;
	assign mk[0] = '0;

	for (genvar p = 0; p < MAX_N; p++) begin : g_pos
		cu_stage #(.POS(p), .MAXN(MAX_N)) u_stage (
			.clk(clk), .arst_n(arst_n), .advance(advance),
			.in_valid(v[p]), .in_cfg(cf[p]), .in_code(cd[p]), .in_c(cc[p]),
			.in_mask(mk[p]),
			.out_valid_s1(v[p+1]), .out_cfg_s1(cf[p+1]), .out_code_s1(cd[p+1]),
			.out_c_s1(cc[p+1]), .out_mask_s1(mk[p+1])
		);
	end

	assign out_valid      = v[MAX_N];
	assign selection_mask = 32'(mk[MAX_N]);

endmodule

[rtl/cu_stage.sv]
// ----------------------------------------------------------------------------
// cu_stage: one position of the unranking walk
// Compare the code with C(u,d), choose the position or subtract.
// ----------------------------------------------------------------------------
module cu_stage #(
	parameter int unsigned POS  = 0,
	parameter int unsigned MAXN = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     advance,
	input  logic                     in_valid,
	input  cu_pkg::cu_cfg_t          in_cfg,
	input  logic [cu_pkg::CodeW-1:0] in_code,
	input  logic [5:0]               in_c,
	input  logic [MAXN-1:0]          in_mask,
	output logic                     out_valid_s1,
	output cu_pkg::cu_cfg_t          out_cfg_s1,
	output logic [cu_pkg::CodeW-1:0] out_code_s1,
	output logic [5:0]               out_c_s1,
	output logic [MAXN-1:0]          out_mask_s1
);
	import cu_pkg::*;

	logic             active;
	logic [5:0]       u;
	logic [5:0]       d;
	logic [BinW-1:0]  t;
	logic             take;
	logic [CodeW-1:0] code_nx;
	logic [5:0]       c_nx;
	logic [MAXN-1:0]  mask_nx;

	always_comb begin
		active  = (6'(POS) < in_cfg.n) && (in_c < in_cfg.r);
		u       = in_cfg.n - 6'd1 - 6'(POS);
		d       = in_cfg.r - 6'd1 - in_c;
		t       = binom_tab(u[4:0], d);
		take    = {1'b0, in_code} < t;
		code_nx = in_code;
		c_nx    = in_c;
		mask_nx = in_mask;
		if (active) begin
			if (take) begin
				mask_nx[POS] = 1'b1;
				c_nx         = in_c + 6'd1;
			end else begin
				code_nx = in_code - t[CodeW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s1 <= 1'b0;
		end else if (advance) begin
			out_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_cfg_s1  <= in_cfg;
			out_code_s1 <= code_nx;
			out_c_s1    <= c_nx;
			out_mask_s1 <= mask_nx;
		end
	end

endmodule

[rtl/cu_checker.sv]
// ----------------------------------------------------------------------------
// cu_checker: port-level assertions for the unranker
// Watches handshakes and result masks.
// ----------------------------------------------------------------------------
module cu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] selection_mask
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(selection_mask))
		else $error("stalled result changed");
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid)
		else $error("stalled request dropped");
endmodule

bind combination_unrank cu_checker u_cu_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .selection_mask(selection_mask)
);
